// File: rtl/core/lnsa_pkg.sv
package lnsa_pkg;

    // Operation codes of the command channel.
    localparam logic [2:0] OP_NOTE_ON     = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF    = 3'd1;
    localparam logic [2:0] OP_ALL_OFF     = 3'd2;
    localparam logic [2:0] OP_CHANNEL_OFF = 3'd3;
    localparam logic [2:0] OP_SWEEP       = 3'd4;
    localparam logic [2:0] OP_READ_SLOT   = 3'd5;
    localparam logic [2:0] OP_CLEAR_ALL   = 3'd6;

    localparam logic [31:0] DURATION_RESET = 32'd1000;
    localparam logic [6:0]  COUNT_MAX      = 7'd127;

    // Contents of one note slot.
    typedef struct packed {
        logic        active;
        logic        released;
        logic [7:0]  port;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [31:0] start;
        logic [31:0] stop;
    } t_slot;

endpackage

// File: rtl/core/lnsa_in_if.sv
interface lnsa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  port;
    logic [3:0]  channel;
    logic [6:0]  note_number;
    logic [31:0] now;
    logic [5:0]  slot_select;

    modport source (output valid, op, port, channel, note_number, now, slot_select,
                    input ready);
    modport sink (input valid, op, port, channel, note_number, now, slot_select,
                  output ready);
endinterface

// File: rtl/core/lnsa_out_if.sv
interface lnsa_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  slot_index;
    logic        found;
    logic        evicted;
    logic [6:0]  active_count;
    logic        read_active;
    logic        read_released;
    logic [7:0]  read_port;
    logic [3:0]  read_channel;
    logic [6:0]  read_note;
    logic [31:0] read_start;
    logic [31:0] read_end;

    modport source (output valid, slot_index, found, evicted, active_count, read_active,
                    read_released, read_port, read_channel, read_note, read_start,
                    read_end, input ready);
    modport sink (input valid, slot_index, found, evicted, active_count, read_active,
                  read_released, read_port, read_channel, read_note, read_start,
                  read_end, output ready);
endinterface

// File: rtl/core/lnsa_cell.sv
module lnsa_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  lnsa_pkg::t_slot i_d,
    output lnsa_pkg::t_slot o_q
);
    import lnsa_pkg::*;

    t_slot r_q;

    // One slot of the ring; it takes its neighbor's slot on every shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

// File: rtl/core/live_note_slot_allocator_core.sv
// A note-on makes a search pass and then an update pass around the ring before its result
// is registered at the output; every other operation makes only the update pass.
// One operation at a time: a new transfer is taken only once the result of the last one
// has been loaded into the output register and the core is idle again.
// Reset (synchronous, active low) empties every slot and sets the display duration to 1000.
module live_note_slot_allocator_core #(
    parameter int SLOT_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    lnsa_in_if.sink     i_in,
    lnsa_out_if.source  o_out
);
    import lnsa_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE, S_DONE} t_state;

    t_state r_state;

    // The slots live in a ring of cells. At rest the last cell holds slot 0, the one
    // before it slot 1 and so on, so a full rotation shows slots 0 .. SLOT_COUNT-1 at
    // the head in index order and returns every slot to its home cell.
    t_slot w_q [SLOT_COUNT];
    t_slot w_head;
    t_slot w_new;
    logic  w_shift;

    assign w_head  = w_q[SLOT_COUNT-1];
    assign w_shift = (r_state == S_SEARCH) || (r_state == S_UPDATE);

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        t_slot w_d;
        if (g == 0) begin : g_first
            assign w_d = (r_state == S_UPDATE) ? w_new : w_head;
        end else begin : g_rest
            assign w_d = w_q[g-1];
        end
        lnsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d),
            .o_q     (w_q[g])
        );
    end

    // Latched command.
    logic [2:0]    r_op;
    logic [7:0]    r_port;
    logic [3:0]    r_chan;
    logic [6:0]    r_note;
    logic [31:0]   r_now;
    logic [5:0]    r_sel;
    logic [31:0]   r_dur;
    logic [IW-1:0] r_pos;

    // Search results of the note-on pass.
    logic          r_free;
    logic [IW-1:0] r_free_idx;
    logic [31:0]   r_min;
    logic [IW-1:0] r_min_idx;

    // Result being built during the update pass.
    logic          r_hit;
    logic [IW-1:0] r_idx;
    logic          r_evict;
    logic [6:0]    r_cnt;
    t_slot         r_rd;

    // Output register.
    logic          r_ov;
    logic [5:0]    r_o_idx;
    logic          r_o_found;
    logic          r_o_evict;
    logic [6:0]    r_o_cnt;
    t_slot         r_o_rd;

    logic          w_expired;
    logic          w_match_key;
    logic          w_match_chan;
    logic          w_open;
    logic          w_take;
    logic [IW-1:0] w_pick;
    logic [6:0]    n_cnt;

    assign w_expired    = w_head.active && w_head.released &&
                          ((r_now - w_head.stop) > r_dur);
    assign w_match_chan = (w_head.port == r_port) && (w_head.channel == r_chan);
    assign w_match_key  = w_match_chan && (w_head.note == r_note);
    assign w_open       = w_head.active && !w_head.released;
    assign w_pick       = r_free ? r_free_idx : r_min_idx;
    assign w_take       = !r_ov || o_out.ready;

    // Head logic: what the slot at the head becomes during the update pass.
    always_comb begin
        w_new = w_head;
        case (r_op)
            OP_NOTE_ON: begin
                if (r_pos == w_pick) begin
                    w_new.active   = 1'b1;
                    w_new.released = 1'b0;
                    w_new.port     = r_port;
                    w_new.channel  = r_chan;
                    w_new.note     = r_note;
                    w_new.start    = r_now;
                    w_new.stop     = '0;
                end
            end
            OP_NOTE_OFF: begin
                if (!r_hit && w_open && w_match_key) begin
                    w_new.released = 1'b1;
                    w_new.stop     = r_now;
                end
            end
            OP_ALL_OFF, OP_CHANNEL_OFF: begin
                if (w_open && (r_op == OP_ALL_OFF || w_match_chan)) begin
                    w_new.released = 1'b1;
                    w_new.stop     = r_now;
                end
            end
            OP_SWEEP: begin
                if (w_expired) begin
                    w_new = '0;
                end
            end
            OP_CLEAR_ALL: begin
                w_new = '0;
            end
            default: begin
            end
        endcase
    end

    assign n_cnt = (w_new.active && r_cnt != COUNT_MAX) ? r_cnt + 7'd1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dur   <= DURATION_RESET;
            r_ov    <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dur <= i_cfg_wdata;
            end
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op   <= i_in.op;
                        r_port <= i_in.port;
                        r_chan <= i_in.channel;
                        r_note <= i_in.note_number;
                        r_now  <= i_in.now;
                        r_sel  <= i_in.slot_select;
                        r_pos  <= '0;
                        r_free <= 1'b0;
                        r_hit  <= 1'b0;
                        r_idx  <= '0;
                        r_cnt  <= '0;
                        r_rd   <= '0;
                        r_state <= (i_in.op == OP_NOTE_ON) ? S_SEARCH : S_UPDATE;
                    end
                end
                S_SEARCH: begin
                    // First free or expired slot, and the oldest start time as fallback.
                    if (!r_free && (!w_head.active || w_expired)) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_pos;
                    end
                    if (r_pos == '0 || w_head.start < r_min) begin
                        r_min     <= w_head.start;
                        r_min_idx <= r_pos;
                    end
                    if (r_pos == LAST) begin
                        r_pos   <= '0;
                        r_state <= S_UPDATE;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_UPDATE: begin
                    r_cnt <= n_cnt;
                    if (r_op == OP_NOTE_ON) begin
                        r_hit   <= 1'b1;
                        r_idx   <= w_pick;
                        r_evict <= !r_free;
                    end else begin
                        r_evict <= 1'b0;
                    end
                    if (r_op == OP_NOTE_OFF && !r_hit && w_open && w_match_key) begin
                        r_hit <= 1'b1;
                        r_idx <= r_pos;
                    end
                    if (r_op == OP_READ_SLOT && 32'(r_pos) == 32'(r_sel)) begin
                        r_rd <= w_head;
                    end
                    if (r_pos == LAST) begin
                        r_pos   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_take) begin
                        r_ov      <= 1'b1;
                        r_o_idx   <= 6'(32'(r_idx));
                        r_o_found <= r_hit;
                        r_o_evict <= r_evict;
                        r_o_cnt   <= r_cnt;
                        r_o_rd    <= r_rd;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.slot_index    = r_o_idx;
    assign o_out.found         = r_o_found;
    assign o_out.evicted       = r_o_evict;
    assign o_out.active_count  = r_o_cnt;
    assign o_out.read_active   = r_o_rd.active;
    assign o_out.read_released = r_o_rd.released;
    assign o_out.read_port     = r_o_rd.port;
    assign o_out.read_channel  = r_o_rd.channel;
    assign o_out.read_note     = r_o_rd.note;
    assign o_out.read_start    = r_o_rd.start;
    assign o_out.read_end      = r_o_rd.stop;

    // An accepted command always starts a pass around the ring.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SEARCH || r_state == S_UPDATE))
        else $error("accepted command did not start a pass");

    // A stolen slot is only reported together with a successful note-on.
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.evicted) |-> o_out.found)
        else $error("eviction reported without a found slot");

    // The slot position is home whenever the core is idle; the ring only moves while a pass runs.
    a_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pos == '0))
        else $error("slot position not home while idle");

    // A finished result is loaded into the output only from the done state.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");
endmodule
